@@ rtl/core/trc_pkg.sv @@
// Shared types, widths and the edge test function of the tile grid ray caster.
// Used by the divider, the controller, the datapath and the top level; depends on nothing.
package trc_pkg;

  // Default map and scan sizes.
  localparam int MAP_SIDE_DEF = 64;
  localparam int MAX_SCAN_DEF = 64;

  // Tile coordinate, edge numerator and cross product widths (signed).
  localparam int COORD_W = 11;
  localparam int N_W     = 20;
  localparam int P_W     = 40;
  // Divider widths: numerator is the edge numerator scaled by 2^14.
  localparam int FRAC_SH = 14;
  localparam int NUM_W   = N_W - 1 + FRAC_SH;
  localparam int DEN_W   = 16;
  localparam int DIST_W  = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic wr_rd;
    logic wr_wb;
    logic set_a;
    logic set_b;
    logic row_start;
    logic tile_step;
    logic div_start;
    logic div_sel_y;
    logic load_out;
  } trc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic tile_last;
    logic row_last;
    logic found_x;
    logic found_y;
    logic div_done;
    logic out_free;
  } trc_sts_t;

  // Outcome of one edge test.
  typedef struct packed {
    logic           ok;
    logic [N_W-2:0] nn;
  } trc_edge_t;

  // Tests one tile edge: the numerator must lie ahead and the crossing must
  // fall on the closed edge span. Signs are folded so the along term is positive.
  function automatic trc_edge_t edge_eval(input logic signed [N_W-1:0] n,
                                          input logic signed [P_W-1:0] p,
                                          input logic                  neg,
                                          input logic [DEN_W-1:0]      qa);
    logic signed [N_W-1:0] nn_s;
    logic signed [P_W-1:0] pp;
    logic signed [P_W-1:0] lim;
    trc_edge_t             r;
    nn_s = neg ? -n : n;
    pp   = neg ? -p : p;
    lim  = P_W'({qa, 8'h00});
    r.ok = !nn_s[N_W-1] && !pp[P_W-1] && (pp <= lim);
    r.nn = nn_s[N_W-2:0];
    return r;
  endfunction

endpackage

@@ rtl/core/trc_div.sv @@
// Restoring divider of the tile grid ray caster, one quotient bit per cycle.
// Depends on trc_pkg for default widths.
module trc_div #(
  parameter int NUM_W = trc_pkg::NUM_W,
  parameter int DEN_W = trc_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // One trial subtraction per cycle.
  always_comb begin
    trial   = {rem_r, q_r[NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/core/trc_dp.sv @@
// Datapath of the tile grid ray caster: occupancy map, scan accumulators,
// edge tests, divider and output register. Depends on trc_pkg and trc_div.
module trc_dp #(
  parameter int MAP_SIDE = trc_pkg::MAP_SIDE_DEF,
  parameter int MAX_SCAN = trc_pkg::MAX_SCAN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  trc_pkg::trc_cmd_t      cmd,
  output trc_pkg::trc_sts_t      sts,
  input  logic [15:0]            in_start_x,
  input  logic [15:0]            in_start_y,
  input  logic signed [15:0]     in_dir_x,
  input  logic signed [15:0]     in_dir_y,
  input  logic [5:0]             in_reach,
  input  logic [5:0]             in_tile_col,
  input  logic [5:0]             in_tile_row,
  input  logic                   in_tile_solid,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_hit,
  output logic [15:0]            out_distance
);

  localparam int AW    = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam int IW    = $clog2(MAX_SCAN);
  localparam int CW    = trc_pkg::COORD_W;
  localparam int N_W   = trc_pkg::N_W;
  localparam int P_W   = trc_pkg::P_W;
  localparam int NUM_W = trc_pkg::NUM_W;
  localparam int DEN_W = trc_pkg::DEN_W;
  localparam int DW    = trc_pkg::DIST_W;
  localparam logic [trc_pkg::FRAC_SH-1:0] FRAC_ZERO = '0;

  // Occupancy map, one row of tiles per word.
  logic [MAP_SIDE-1:0] map_mem [MAP_SIDE];
  logic [MAP_SIDE-1:0] row_q_r;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_wa;
  logic [AW-1:0]       mem_ra;
  logic [MAP_SIDE-1:0] mem_wd;

  logic [AW-1:0]          clr_r;
  logic [15:0]            sx_r, sy_r;
  logic signed [15:0]     vx_r, vy_r;
  logic [IW-1:0]          last_r, i_r, j_r;
  logic signed [CW-1:0]   tx_r, x_r, y_r;
  logic signed [N_W-1:0]  nx_r, ny_r;
  logic signed [P_W-1:0]  px_r, prow_r, prod_r;
  logic                   row_ok_r;
  logic [5:0]             col_r, rowi_r;
  logic                   solid_r, wr_ok_r;
  logic [N_W-2:0]         bx_r, by_r, bx_nxt, by_nxt;
  logic                   fx_r, fy_r, fx_nxt, fy_nxt;
  logic [DW-1:0]          best_r;
  logic                   found_r;
  logic                   out_valid_r, out_hit_r;
  logic [DW-1:0]          out_dist_r;

  logic signed [P_W-1:0]  vxe, vye, dpx, drow;
  logic [DEN_W-1:0]       qax, qay;
  logic                   x_in, y_in, solid;
  trc_pkg::trc_edge_t     ex0, ex1, ey0, ey1;
  logic                   div_done;
  logic [NUM_W-1:0]       quo;
  logic [DW-1:0]          tsat;
  logic [IW-1:0]          last_in;

  // Direction magnitudes and per-step increments of the cross products.
  always_comb begin
    vxe  = P_W'(vx_r);
    vye  = P_W'(vy_r);
    qax  = vx_r[15] ? DEN_W'(-vx_r) : DEN_W'(vx_r);
    qay  = vy_r[15] ? DEN_W'(-vy_r) : DEN_W'(vy_r);
    dpx  = (vx_r[15] ? -vye : vye) <<< 8;
    drow = (vy_r[15] ? vxe : -vxe) <<< 8;
  end

  // Scan extent: reach plus one tiles per side, capped.
  assign last_in = (int'(in_reach) > MAX_SCAN - 1) ? IW'(MAX_SCAN - 1) : IW'(in_reach);

  // Current tile lookup; tiles off the map read as open.
  always_comb begin
    x_in  = !x_r[CW-1] && (x_r < MAP_SIDE);
    y_in  = !y_r[CW-1] && (y_r < MAP_SIDE);
    solid = x_in && row_ok_r && row_q_r[AW'(x_r)];
  end

  // Edge tests on each x edge and each y edge of the current tile.
  always_comb begin
    ex0 = trc_pkg::edge_eval(nx_r, px_r, vx_r[15], qax);
    ex1 = trc_pkg::edge_eval(nx_r + N_W'(256), px_r + (vye <<< 8), vx_r[15], qax);
    ey0 = trc_pkg::edge_eval(ny_r, -px_r, vy_r[15], qay);
    ey1 = trc_pkg::edge_eval(ny_r + N_W'(256), (vxe <<< 8) - px_r, vy_r[15], qay);
  end

  // Smallest numerator per axis; on one axis the divisor is fixed.
  always_comb begin
    bx_nxt = bx_r;
    fx_nxt = fx_r;
    by_nxt = by_r;
    fy_nxt = fy_r;
    if (cmd.tile_step && solid && (vx_r != '0)) begin
      if (ex0.ok && (!fx_nxt || ex0.nn < bx_nxt)) begin
        bx_nxt = ex0.nn;
        fx_nxt = 1'b1;
      end
      if (ex1.ok && (!fx_nxt || ex1.nn < bx_nxt)) begin
        bx_nxt = ex1.nn;
        fx_nxt = 1'b1;
      end
    end
    if (cmd.tile_step && solid && (vy_r != '0)) begin
      if (ey0.ok && (!fy_nxt || ey0.nn < by_nxt)) begin
        by_nxt = ey0.nn;
        fy_nxt = 1'b1;
      end
      if (ey1.ok && (!fy_nxt || ey1.nn < by_nxt)) begin
        by_nxt = ey1.nn;
        fy_nxt = 1'b1;
      end
    end
  end

  // Map port selection: clearing, tile write and row fetch.
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = clr_r;
    mem_ra = AW'(y_r);
    mem_wd = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end
    if (cmd.wr_wb) begin
      mem_we = wr_ok_r;
      mem_wa = AW'(rowi_r);
      mem_wd = row_q_r;
      mem_wd[AW'(col_r)] = solid_r;
    end
    if (cmd.wr_rd) begin
      mem_re = 1'b1;
      mem_ra = AW'(rowi_r);
    end
    if (cmd.row_start) begin
      mem_re = y_in;
    end
  end

  // Map storage with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      row_q_r <= map_mem[mem_ra];
    end
  end

  // Clearing pass row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Input capture, setup products and scan accumulators.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sx_r    <= in_start_x;
      sy_r    <= in_start_y;
      vx_r    <= in_dir_x;
      vy_r    <= in_dir_y;
      last_r  <= last_in;
      tx_r    <= $signed(CW'(in_start_x[15:8]));
      y_r     <= $signed(CW'(in_start_y[15:8]));
      ny_r    <= -$signed(N_W'(in_start_y[7:0]));
      j_r     <= '0;
      col_r   <= in_tile_col;
      rowi_r  <= in_tile_row;
      solid_r <= in_tile_solid;
      wr_ok_r <= (int'(in_tile_col) < MAP_SIDE) && (int'(in_tile_row) < MAP_SIDE);
      bx_r    <= '0;
      by_r    <= '0;
      fx_r    <= 1'b0;
      fy_r    <= 1'b0;
    end else begin
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
    end
    if (cmd.set_a) begin
      prod_r <= P_W'($signed({1'b0, sy_r[7:0]}) * vx_r);
    end
    if (cmd.set_b) begin
      prow_r <= prod_r - P_W'($signed({1'b0, sx_r[7:0]}) * vy_r);
    end
    if (cmd.row_start) begin
      x_r      <= tx_r;
      nx_r     <= -$signed(N_W'(sx_r[7:0]));
      px_r     <= prow_r;
      i_r      <= '0;
      row_ok_r <= y_in;
    end
    if (cmd.tile_step) begin
      x_r  <= vx_r[15] ? x_r - CW'(1) : x_r + CW'(1);
      nx_r <= vx_r[15] ? nx_r - N_W'(256) : nx_r + N_W'(256);
      px_r <= px_r + dpx;
      i_r  <= i_r + 1'b1;
      if (i_r == last_r) begin
        y_r    <= vy_r[15] ? y_r - CW'(1) : y_r + CW'(1);
        ny_r   <= vy_r[15] ? ny_r - N_W'(256) : ny_r + N_W'(256);
        prow_r <= prow_r + drow;
        j_r    <= j_r + 1'b1;
      end
    end
  end

  // Shared divider turns the best numerator of one axis into a distance.
  trc_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (cmd.div_sel_y ? {by_r, FRAC_ZERO} : {bx_r, FRAC_ZERO}),
    .den  (cmd.div_sel_y ? qay : qax),
    .done (div_done),
    .quo  (quo)
  );

  assign tsat = (quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : DW'(quo);

  // Fold each axis distance into the best result.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      best_r  <= '0;
      found_r <= 1'b0;
    end else if (div_done && (!found_r || tsat < best_r)) begin
      best_r  <= tsat;
      found_r <= 1'b1;
    end
  end

  // Output register; a beat leaves when out_ready is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r  <= found_r;
      out_dist_r <= found_r ? best_r : '0;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.clr_last  = (clr_r == AW'(MAP_SIDE - 1));
    sts.tile_last = (i_r == last_r);
    sts.row_last  = (j_r == last_r);
    sts.found_x   = fx_r;
    sts.found_y   = fy_r;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;

endmodule

@@ rtl/core/trc_ctrl.sv @@
// Controller state machine of the tile grid ray caster.
// Depends on trc_pkg for the command and status types.
module trc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  trc_pkg::trc_sts_t sts,
  output trc_pkg::trc_cmd_t cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WR_RD  = 4'd2;
  localparam logic [3:0] S_WR_WB  = 4'd3;
  localparam logic [3:0] S_SET_A  = 4'd4;
  localparam logic [3:0] S_SET_B  = 4'd5;
  localparam logic [3:0] S_ROW    = 4'd6;
  localparam logic [3:0] S_TILE   = 4'd7;
  localparam logic [3:0] S_DIVX   = 4'd8;
  localparam logic [3:0] S_WAITX  = 4'd9;
  localparam logic [3:0] S_DIVY   = 4'd10;
  localparam logic [3:0] S_WAITY  = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  localparam logic MODE_WRITE = 1'b1;

  logic [3:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_mode == MODE_WRITE) ? S_WR_RD : S_SET_A;
        end
      end
      S_WR_RD: begin
        cmd.wr_rd = 1'b1;
        state_nxt = S_WR_WB;
      end
      S_WR_WB: begin
        cmd.wr_wb = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SET_A: begin
        cmd.set_a = 1'b1;
        state_nxt = S_SET_B;
      end
      S_SET_B: begin
        cmd.set_b = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row_start = 1'b1;
        state_nxt     = S_TILE;
      end
      S_TILE: begin
        cmd.tile_step = 1'b1;
        if (sts.tile_last) begin
          state_nxt = sts.row_last ? S_DIVX : S_ROW;
        end
      end
      S_DIVX: begin
        cmd.div_start = sts.found_x;
        state_nxt     = sts.found_x ? S_WAITX : S_DIVY;
      end
      S_WAITX: begin
        if (sts.div_done) begin
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_sel_y = 1'b1;
        cmd.div_start = sts.found_y;
        state_nxt     = sts.found_y ? S_WAITY : S_RESULT;
      end
      S_WAITY: begin
        if (sts.div_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the map clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The last tile of the last row hands over to the division phase.
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TILE) && sts.tile_last && sts.row_last |=> (state_r == S_DIVX))
    else $error("scan did not end at the last tile");

  // The divider only reports while the controller waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_WAITX) || (state_r == S_WAITY))
    else $error("divider finished outside a wait state");

  // The clearing pass ends at the last map row and opens the input.
  a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) && sts.clr_last |=> (state_r == S_IDLE))
    else $error("clearing pass did not end at the last row");

endmodule

@@ rtl/core/tile_grid_ray_cast_top.sv @@
// Top level of the tile grid ray caster: controller plus datapath.
// Depends on trc_pkg, trc_ctrl and trc_dp.
//
// Usage: one input channel (in_valid/in_ready) takes a beat that either
// writes one map tile (in_mode high) or casts a ray (in_mode low). Only a
// cast returns a beat on the output channel (out_valid/out_ready) with
// out_hit and out_distance (Q8.8, saturated, zero when nothing is hit).
// Items are handled one at a time; in_ready is high only while idle.
// A write goes from acceptance to a read and then a write back of the map row.
// A cast runs two setup steps, then for each of S rows one row fetch and S
// tile steps, S = min(reach+1, MAX_SCAN); then per axis a start step and,
// if that axis saw a hit, a 33-step divider pass and its done flag; last,
// the output register is loaded.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, a finished cast holds until the
// register frees up.
// Reset (rst_n low, synchronous) runs a clearing pass over all MAP_SIDE
// map rows, one map row per cycle, during which in_ready stays low.
module tile_grid_ray_cast_top #(
  parameter int MAP_SIDE = trc_pkg::MAP_SIDE_DEF,
  parameter int MAX_SCAN = trc_pkg::MAX_SCAN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [15:0]        in_start_x,
  input  logic [15:0]        in_start_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [5:0]         in_reach,
  input  logic [5:0]         in_tile_col,
  input  logic [5:0]         in_tile_row,
  input  logic               in_tile_solid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [15:0]        out_distance
);

  trc_pkg::trc_cmd_t cmd;
  trc_pkg::trc_sts_t sts;

  // Sequencer.
  trc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_mode (in_mode),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Map, scan arithmetic and output register.
  trc_dp #(
    .MAP_SIDE(MAP_SIDE),
    .MAX_SCAN(MAX_SCAN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_dir_x     (in_dir_x),
    .in_dir_y     (in_dir_y),
    .in_reach     (in_reach),
    .in_tile_col  (in_tile_col),
    .in_tile_row  (in_tile_row),
    .in_tile_solid(in_tile_solid),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_distance (out_distance)
  );

endmodule
